// File: design/stvg_pkg.sv
// Shared types, constants and sizes of the stepper tone voice generator.
package stvg_pkg;

    localparam int VOICES   = 4;
    localparam int SUBSTEPS = 4;
    localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUB_W    = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);
    localparam logic [SUB_W-1:0]   LAST_SUB   = SUB_W'(SUBSTEPS - 1);

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_ON    = 2'd1;
    localparam logic [1:0] ST_OFF   = 2'd2;

    localparam logic [3:0] COIL_PATTERN [4] = '{4'b0001, 4'b0010, 4'b0100, 4'b1000};

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               ev_load;
        logic               step_en;
        logic [VOICE_W-1:0] voice;
        logic               word_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// File: design/stepper_tone_voice_generator.sv
// Top level of the four-voice stepper tone voice generator.
// The input channel carries one item per event: a tick, a note on with its
// period, a note off, or another command that clears all voices.
// An item is accepted when i_valid is high and o_stall is low.
// A note event updates the voice table at the edge that accepts it and
// causes no result; the next item can be accepted in the following cycle.
// A tick runs one counter step per voice per substep on a single shared
// step unit in state S_TICK, then moves to S_DONE and loads the output
// register as the result once it is free; the block then returns to idle
// and takes the next item.
// The output channel presents o_coil_word with o_valid until the receiver
// drops i_stall. While the result waits, the block can accept and apply
// note events; a new tick stalls in its final cycle until the register frees.
// Reset is synchronous and active low; it empties all voices, zeroes their
// periods, counts and phases, and drops o_valid.
module stepper_tone_voice_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_note,
    input  logic [15:0] i_period,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_coil_word
);

    stvg_pkg::t_cmd    cmd;
    stvg_pkg::t_status status;

    stvg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    stvg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_kind),
        .i_note      (i_note),
        .i_period    (i_period),
        .i_stall     (i_stall),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_coil_word (o_coil_word)
    );

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == stvg_pkg::KIND_TICK |=> o_stall)
        else $error("Accepted tick did not make the block busy.");

    a_event_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind != stvg_pkg::KIND_TICK |=> !o_stall)
        else $error("Note event held the input side busy.");

    a_word_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_coil_word[3:0]) && $onehot0(o_coil_word[7:4]) &&
                    $onehot0(o_coil_word[11:8]) && $onehot0(o_coil_word[15:12]))
        else $error("Coil nibble has more than one phase set.");

    a_no_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !cmd.step_en && !cmd.word_load)
        else $error("Datapath commanded while the controller is idle.");

endmodule

// File: design/stvg_ctrl.sv
// Controller state machine that sequences note events, tick steps and result loading.
module stvg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  stvg_pkg::t_status i_status,
    output logic              o_stall,
    output stvg_pkg::t_cmd    o_cmd
);

    stvg_pkg::t_state r_state, n_state;
    logic [stvg_pkg::VOICE_W-1:0] r_voice, n_voice;
    logic [stvg_pkg::SUB_W-1:0]   r_sub, n_sub;
    logic accept;

    assign accept = i_valid && (r_state == stvg_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stvg_pkg::S_IDLE;
            r_voice <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_sub   <= n_sub;
        end
    end

    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        n_sub   = r_sub;
        case (r_state)
            stvg_pkg::S_IDLE: begin
                n_voice = '0;
                n_sub   = '0;
                if (accept && i_kind == stvg_pkg::KIND_TICK) begin
                    n_state = stvg_pkg::S_TICK;
                end
            end
            stvg_pkg::S_TICK: begin
                if (r_voice == stvg_pkg::LAST_VOICE) begin
                    n_voice = '0;
                    n_sub   = r_sub + 1'b1;
                    if (r_sub == stvg_pkg::LAST_SUB) begin
                        n_state = stvg_pkg::S_DONE;
                    end
                end else begin
                    n_voice = r_voice + 1'b1;
                end
            end
            stvg_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = stvg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stvg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.voice = r_voice;
        o_stall     = 1'b1;
        case (r_state)
            stvg_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.ev_load = accept && (i_kind != stvg_pkg::KIND_TICK);
            end
            stvg_pkg::S_TICK: begin
                o_cmd.step_en = 1'b1;
            end
            stvg_pkg::S_DONE: begin
                o_cmd.word_load = i_status.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: design/stvg_dp.sv
// Datapath holding the voice registers, the step unit and the output register.
module stvg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stvg_pkg::t_cmd    i_cmd,
    input  logic [1:0]        i_kind,
    input  logic [6:0]        i_note,
    input  logic [15:0]       i_period,
    input  logic              i_stall,
    output stvg_pkg::t_status o_status,
    output logic              o_valid,
    output logic [15:0]       o_coil_word
);

    logic [1:0]  r_status [stvg_pkg::VOICES];
    logic [6:0]  r_note   [stvg_pkg::VOICES];
    logic [15:0] r_period [stvg_pkg::VOICES];
    logic [15:0] r_count  [stvg_pkg::VOICES];
    logic [1:0]  r_phase  [stvg_pkg::VOICES];
    logic [1:0]  n_status [stvg_pkg::VOICES];
    logic [6:0]  n_note   [stvg_pkg::VOICES];
    logic [15:0] n_period [stvg_pkg::VOICES];
    logic        r_out_valid;
    logic [15:0] r_word;
    logic [15:0] word;
    logic [15:0] step_count;
    logic        step_wrap;
    logic        done;

    always_comb begin
        n_status = r_status;
        n_note   = r_note;
        n_period = r_period;
        done     = 1'b0;
        if (i_kind == stvg_pkg::KIND_NOTE_OFF) begin
            for (int v = 0; v < stvg_pkg::VOICES; v++) begin
                if (!done && r_note[v] == i_note) begin
                    n_status[v] = stvg_pkg::ST_OFF;
                    done        = 1'b1;
                end
            end
        end
        if (i_kind == stvg_pkg::KIND_NOTE_ON) begin
            for (int v = 0; v < stvg_pkg::VOICES; v++) begin
                if (!done && r_status[v] != stvg_pkg::ST_ON) begin
                    n_status[v] = stvg_pkg::ST_ON;
                    n_note[v]   = i_note;
                    n_period[v] = i_period;
                    done        = 1'b1;
                end
            end
        end
        if (!done) begin
            for (int v = 0; v < stvg_pkg::VOICES; v++) begin
                n_status[v] = stvg_pkg::ST_EMPTY;
                n_note[v]   = '0;
                n_period[v] = '0;
            end
        end
    end

    assign step_wrap  = r_count[i_cmd.voice] > r_period[i_cmd.voice];
    assign step_count = step_wrap ? 16'd1 : r_count[i_cmd.voice] + 16'd1;

    always_comb begin
        word = '0;
        for (int v = 0; v < stvg_pkg::VOICES; v++) begin
            if (r_status[v] == stvg_pkg::ST_ON) begin
                word[4*v +: 4] = stvg_pkg::COIL_PATTERN[r_phase[v]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < stvg_pkg::VOICES; v++) begin
                r_status[v] <= stvg_pkg::ST_EMPTY;
                r_note[v]   <= '0;
                r_period[v] <= '0;
                r_count[v]  <= '0;
                r_phase[v]  <= '0;
            end
        end else begin
            if (i_cmd.ev_load) begin
                r_status <= n_status;
                r_note   <= n_note;
                r_period <= n_period;
            end
            if (i_cmd.step_en) begin
                r_count[i_cmd.voice] <= step_count;
                if (step_wrap) begin
                    r_phase[i_cmd.voice] <= r_phase[i_cmd.voice] + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.word_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.word_load) begin
            r_word <= word;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_coil_word       = r_word;

endmodule
